>>> rtl/dual_chip_lcd_cursor_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// dual chip lcd cursor sequencer assertion macros
// immediate-consequence and next-cycle property checks with disable on reset
// ----------------------------------------------------------------------------
`ifndef DUAL_CHIP_LCD_CURSOR_SEQUENCER_UNIT_DEFINES_SVH
`define DUAL_CHIP_LCD_CURSOR_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define DCCS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DCCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dccs_pkg.sv
// ----------------------------------------------------------------------------
// dccs_pkg
// types and constants shared by the lcd cursor sequencer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dccs_pkg;

  localparam int unsigned COLUMNS_PER_CHIP_DEF = 64;
  localparam int unsigned PAGE_COUNT_DEF       = 8;

  localparam int unsigned COL_W       = 7;
  localparam int unsigned PAGE_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] HALF_NONE  = 2'd0;
  localparam logic [1:0] HALF_LEFT  = 2'd1;
  localparam logic [1:0] HALF_RIGHT = 2'd2;
  localparam logic [1:0] CS_BOTH    = 2'd3;

  localparam logic [7:0] SET_COL_MASK  = 8'hC0;
  localparam logic [7:0] SET_COL_CODE  = 8'h40;
  localparam logic [7:0] COL_MASK      = 8'h3F;
  localparam logic [7:0] SET_PAGE_MASK = 8'hF8;
  localparam logic [7:0] SET_PAGE_CODE = 8'hB8;
  localparam logic [7:0] PAGE_MASK     = 8'h07;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] bus_byte;
    logic [1:0] chip_select;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_not_write;
    logic       left_enable;
    logic       right_enable;
    logic [7:0] drive_byte;
    logic       sample_read;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_CMD   = 2'd0,
    JOB_WRITE = 2'd1,
    JOB_READ  = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic              lead;
    logic [PAGE_W-1:0] lead_page;
    job_kind_e         kind;
    logic              fin;
    logic              le;
    logic              re;
    logic [7:0]        data;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/dccs_front.sv
// ----------------------------------------------------------------------------
// dccs_front
// accepts requests, tracks the shadow cursor, turns all but OP_NONE into jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccs_front
  import dccs_pkg::*;
#(
  parameter int unsigned COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
  parameter int unsigned PAGE_COUNT       = PAGE_COUNT_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_item_i,
  input  wire logic     full_i,
  output logic          push_o,
  output job_t          job_o
);

  logic [COL_W-1:0]  column_q, column_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [1:0]        half_q, half_d;

  logic              accept;
  logic              wrap;
  logic [PAGE_W:0]   page_inc;
  logic [PAGE_W-1:0] page_w;
  logic [1:0]        half_w;
  logic [COL_W-1:0]  col_w;
  logic [COL_W-1:0]  col_inc;
  logic              lead;
  logic              fin;

  assign accept = in_valid_i && !full_i;

  always_comb begin
    // leading wrap
    wrap     = column_q >= COL_W'(COLUMNS_PER_CHIP);
    page_inc = {1'b0, page_q} + (PAGE_W+1)'(1);
    page_w   = page_q;
    half_w   = half_q;
    col_w    = column_q;
    lead     = 1'b0;
    if (wrap) begin
      col_w = '0;
      if (half_q == HALF_LEFT) begin
        half_w = HALF_RIGHT;
      end else if (half_q == HALF_RIGHT) begin
        page_w = (page_inc >= (PAGE_W+1)'(PAGE_COUNT)) ? '0 : page_inc[PAGE_W-1:0];
        half_w = HALF_LEFT;
        lead   = 1'b1;
      end
    end
    col_inc = col_w + COL_W'(1);
    fin     = (col_inc >= COL_W'(COLUMNS_PER_CHIP)) &&
              (page_w == PAGE_W'(PAGE_COUNT - 1)) && (half_w == HALF_RIGHT);

    column_d = column_q;
    page_d   = page_q;
    half_d   = half_q;

    job_o.lead      = lead;
    job_o.lead_page = page_w;
    job_o.kind      = JOB_CMD;
    job_o.fin       = fin;
    job_o.le        = half_w == HALF_LEFT;
    job_o.re        = half_w == HALF_RIGHT;
    job_o.data      = in_item_i.bus_byte;
    push_o          = 1'b0;

    case (in_item_i.op)
      OP_CMD: begin
        push_o     = accept;
        job_o.lead = 1'b0;
        job_o.le   = in_item_i.chip_select[0];
        job_o.re   = in_item_i.chip_select[1];
        if ((in_item_i.bus_byte & SET_COL_MASK) == SET_COL_CODE) begin
          column_d = COL_W'(in_item_i.bus_byte & COL_MASK);
        end
        if ((in_item_i.bus_byte & SET_PAGE_MASK) == SET_PAGE_CODE) begin
          page_d = PAGE_W'(in_item_i.bus_byte & PAGE_MASK);
        end
        if (in_item_i.chip_select != CS_BOTH) begin
          half_d = in_item_i.chip_select;
        end
      end
      OP_WRITE: begin
        push_o     = accept;
        job_o.kind = JOB_WRITE;
        if (fin) begin
          column_d = '0;
          page_d   = '0;
          half_d   = HALF_LEFT;
        end else begin
          column_d = col_inc;
          page_d   = page_w;
          half_d   = half_w;
        end
      end
      OP_READ: begin
        push_o     = accept;
        job_o.kind = JOB_READ;
        column_d   = col_inc;
        page_d     = page_w;
        half_d     = half_w;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      page_q   <= '0;
      half_q   <= HALF_LEFT;
    end else if (accept) begin
      column_q <= column_d;
      page_q   <= page_d;
      half_q   <= half_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dccs_queue.sv
// ----------------------------------------------------------------------------
// dccs_queue
// small job queue between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccs_queue
  import dccs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire job_t    push_job_i,
  input  wire logic    pop_i,
  output job_t          head_o,
  output queue_status_t status_o
);

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
    status_o.empty = count_q == '0;
    status_o.full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
    head_o         = slots_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dccs_back.sv
// ----------------------------------------------------------------------------
// dccs_back
// expands each job into one to three panel bus cycles behind an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dccs_back
  import dccs_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire job_t          head_i,
  input  wire queue_status_t status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output out_item_t          out_item_o
);

  typedef enum logic [2:0] {
    ST_START = 3'b001,
    ST_MAIN  = 3'b010,
    ST_TAIL  = 3'b100
  } beat_state_e;

  beat_state_e state_q, state_d, state_nxt;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        load;
  logic        go;
  logic        done;
  logic        has_tail;
  out_item_t   lead_beat, main_beat, tail_beat, beat;

  always_comb begin
    load     = !out_valid_q || !out_stall_i;
    go       = load && !status_i.empty;
    has_tail = (head_i.kind == JOB_READ) || ((head_i.kind == JOB_WRITE) && head_i.fin);

    lead_beat = '{reg_select: 1'b0, read_not_write: 1'b0, left_enable: 1'b1,
                  right_enable: 1'b1,
                  drive_byte: SET_PAGE_CODE | {5'b0, head_i.lead_page},
                  sample_read: 1'b0, last: 1'b0};

    main_beat = '{reg_select: 1'b1, read_not_write: 1'b0, left_enable: head_i.le,
                  right_enable: head_i.re, drive_byte: head_i.data,
                  sample_read: 1'b0, last: 1'b1};
    tail_beat = '{reg_select: 1'b0, read_not_write: 1'b0, left_enable: 1'b1,
                  right_enable: 1'b1, drive_byte: SET_PAGE_CODE,
                  sample_read: 1'b0, last: 1'b1};
    case (head_i.kind)
      JOB_CMD: begin
        main_beat.reg_select = 1'b0;
      end
      JOB_WRITE: begin
        main_beat.last = !head_i.fin;
      end
      JOB_READ: begin
        main_beat.read_not_write = 1'b1;
        main_beat.drive_byte     = '0;
        main_beat.last           = 1'b0;
        tail_beat.reg_select     = 1'b1;
        tail_beat.read_not_write = 1'b1;
        tail_beat.left_enable    = head_i.le;
        tail_beat.right_enable   = head_i.re;
        tail_beat.drive_byte     = '0;
        tail_beat.sample_read    = 1'b1;
      end
      default: begin
        main_beat = '0;
      end
    endcase

    beat      = main_beat;
    state_nxt = has_tail ? ST_TAIL : ST_START;
    done      = !has_tail;
    case (state_q)
      ST_START: begin
        if (head_i.lead) begin
          beat      = lead_beat;
          state_nxt = ST_MAIN;
          done      = 1'b0;
        end
      end
      ST_MAIN: begin
        beat = main_beat;
      end
      ST_TAIL: begin
        beat      = tail_beat;
        state_nxt = ST_START;
        done      = 1'b1;
      end
      default: begin
        beat      = main_beat;
        state_nxt = ST_START;
        done      = 1'b1;
      end
    endcase

    pop_o       = go && done;
    state_d     = go ? state_nxt : state_q;
    out_valid_d = load ? !status_i.empty : out_valid_q;
    out_d       = go ? beat : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

>>> rtl/dual_chip_lcd_cursor_sequencer_unit.sv
// ----------------------------------------------------------------------------
// dual_chip_lcd_cursor_sequencer_unit
// shadow cursor for a two-controller graphic panel, emitting panel bus cycles
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  in_item_t (op, byte, select)
//   out      output     out_valid_o / out_stall_i out_item_t (one bus cycle)
//
// a request is taken every cycle while the four-entry job queue has room
// each queued request yields one to three bus cycles from the back part, one per
// clock while the output is not stalled; that expansion sets the sustained rate
// reset puts the cursor at column 0, page 0, left half, with queue empty
// a stalled output holds its bus cycle; the front keeps filling the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_chip_lcd_cursor_sequencer_unit_defines.svh"

module dual_chip_lcd_cursor_sequencer_unit
  import dccs_pkg::*;
#(
  parameter int unsigned COLUMNS_PER_CHIP = COLUMNS_PER_CHIP_DEF,
  parameter int unsigned PAGE_COUNT       = PAGE_COUNT_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;
  queue_status_t q_status;

  assign in_stall_o = q_status.full;

  dccs_front #(
    .COLUMNS_PER_CHIP(COLUMNS_PER_CHIP),
    .PAGE_COUNT      (PAGE_COUNT)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .full_i    (q_status.full),
    .push_o    (push),
    .job_o     (push_job)
  );

  dccs_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (q_status)
  );

  dccs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .status_i   (q_status),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  `DCCS_ASSERT_NOW(a_sample_is_data_read, clk_i, rst_ni, out_valid_o && out_item_o.sample_read, out_item_o.reg_select && out_item_o.read_not_write && out_item_o.last, "sampled cycle is not a final data read")
  `DCCS_ASSERT_NOW(a_cmd_never_reads, clk_i, rst_ni, out_valid_o && !out_item_o.reg_select, !out_item_o.read_not_write && !out_item_o.sample_read, "command cycle marked as read")
  `DCCS_ASSERT_NEXT(a_drain_when_empty, clk_i, rst_ni, out_valid_o && !out_stall_i && q_status.empty, !out_valid_o, "bus cycle shown with no queued job")
  `DCCS_ASSERT_NOW(a_pop_needs_job, clk_i, rst_ni, pop, !q_status.empty, "queue popped while empty")

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench for dual_chip_lcd_cursor_sequencer_unit
// drives command, data write and data read requests through the valid/stall
// input channel and checks every panel bus cycle against a shadow cursor
// predictor (column, page, active half) kept in a small scoreboard class;
// both sides idle in random bursts, the receiver holds off once for a long
// stretch and the sender drains the block once before going on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import dccs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 20;

  class lcd_bus_scoreboard;
    out_item_t             bus_cycles_due[$];
    logic [COL_W-1:0]      cur_col;
    logic [PAGE_W-1:0]     cur_page;
    logic [1:0]            cur_half;
    int unsigned           failures;
    int unsigned           requests_seen;
    int unsigned           cycles_checked;
    int unsigned           reads_seen;
    int unsigned           page_advances;
    int unsigned           panel_ends;

    function new();
      cur_col        = '0;
      cur_page       = '0;
      cur_half       = HALF_LEFT;
      failures       = 0;
      requests_seen  = 0;
      cycles_checked = 0;
      reads_seen     = 0;
      page_advances  = 0;
      panel_ends     = 0;
    endfunction

    function out_item_t bus_cycle(logic rs, logic rw, logic le, logic re,
                                  logic [7:0] data, logic smp, logic lst);
      out_item_t c;
      c.reg_select     = rs;
      c.read_not_write = rw;
      c.left_enable    = le;
      c.right_enable   = re;
      c.drive_byte     = data;
      c.sample_read    = smp;
      c.last           = lst;
      return c;
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function string show(out_item_t c);
      return $sformatf("rs=%0b rw=%0b le=%0b re=%0b byte=%02h smp=%0b last=%0b",
                       c.reg_select, c.read_not_write, c.left_enable,
                       c.right_enable, c.drive_byte, c.sample_read, c.last);
    endfunction

    function int outstanding();
      return bus_cycles_due.size();
    endfunction

    // shadow cursor update and bus cycle prediction for one accepted request
    function void take_request(in_item_t req);
      logic le;
      logic re;
      logic panel_end;
      int   nxt;
      requests_seen++;
      if (req.op == OP_CMD) begin
        if ((req.bus_byte & SET_COL_MASK) == SET_COL_CODE)
          cur_col = COL_W'(req.bus_byte & COL_MASK);
        if ((req.bus_byte & SET_PAGE_MASK) == SET_PAGE_CODE)
          cur_page = PAGE_W'(req.bus_byte & PAGE_MASK);
        if (req.chip_select != CS_BOTH) cur_half = req.chip_select;
        bus_cycles_due.push_back(bus_cycle(1'b0, 1'b0, req.chip_select[0],
                                           req.chip_select[1], req.bus_byte,
                                           1'b0, 1'b1));
      end else if (req.op != OP_NONE) begin
        // leading wrap at the end of a half
        if (cur_col >= COLUMNS_PER_CHIP_DEF) begin
          if (cur_half == HALF_LEFT) begin
            cur_half = HALF_RIGHT;
          end else if (cur_half == HALF_RIGHT) begin
            nxt = int'(cur_page) + 1;
            if (nxt >= PAGE_COUNT_DEF) nxt = 0;
            cur_page = nxt[PAGE_W-1:0];
            bus_cycles_due.push_back(bus_cycle(1'b0, 1'b0, 1'b1, 1'b1,
                                               SET_PAGE_CODE | {5'd0, cur_page},
                                               1'b0, 1'b0));
            cur_half = HALF_LEFT;
            page_advances++;
          end
          cur_col = '0;
        end
        le = (cur_half == HALF_LEFT);
        re = (cur_half == HALF_RIGHT);
        if (req.op == OP_WRITE) begin
          cur_col   = cur_col + 1'b1;
          panel_end = (cur_col >= COLUMNS_PER_CHIP_DEF) &&
                      (cur_page == PAGE_W'(PAGE_COUNT_DEF - 1)) &&
                      (cur_half == HALF_RIGHT);
          bus_cycles_due.push_back(bus_cycle(1'b1, 1'b0, le, re, req.bus_byte,
                                             1'b0, !panel_end));
          if (panel_end) begin
            cur_col  = '0;
            cur_page = '0;
            cur_half = HALF_LEFT;
            bus_cycles_due.push_back(bus_cycle(1'b0, 1'b0, 1'b1, 1'b1,
                                               SET_PAGE_CODE, 1'b0, 1'b1));
            panel_ends++;
          end
        end else begin
          bus_cycles_due.push_back(bus_cycle(1'b1, 1'b1, le, re, 8'h00, 1'b0, 1'b0));
          bus_cycles_due.push_back(bus_cycle(1'b1, 1'b1, le, re, 8'h00, 1'b1, 1'b1));
          cur_col = cur_col + 1'b1;
          reads_seen++;
        end
      end
    endfunction

    function void check_bus_cycle(out_item_t got);
      out_item_t exp;
      cycles_checked++;
      if (bus_cycles_due.size() == 0) begin
        flag({"unexpected bus cycle ", show(got)});
        return;
      end
      exp = bus_cycles_due.pop_front();
      if (got.reg_select     !== exp.reg_select     ||
          got.read_not_write !== exp.read_not_write ||
          got.left_enable    !== exp.left_enable    ||
          got.right_enable   !== exp.right_enable   ||
          got.drive_byte     !== exp.drive_byte     ||
          got.sample_read    !== exp.sample_read    ||
          got.last           !== exp.last)
        flag({"expected ", show(exp), " got ", show(got)});
    endfunction

    function void report_leftovers();
      while (bus_cycles_due.size() != 0)
        flag({"missing bus cycle ", show(bus_cycles_due.pop_front())});
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  in_item_t    in_item = '0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_item_o;

  logic        rx_idle_on = 1'b0;
  logic        hold_active = 1'b0;
  bit          tx_idle_on;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  event        start_hold;

  lcd_bus_scoreboard sb = new();

  dual_chip_lcd_cursor_sequencer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // request noted before the bus cycle of the same edge is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.take_request(in_item);
      if (out_valid_o && !out_stall) sb.check_bus_cycle(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    if (hold_active) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    forever begin
      @(start_hold);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  function automatic in_item_t make_request(logic [1:0] op, logic [7:0] data,
                                            logic [1:0] cs);
    in_item_t r;
    r.op          = op;
    r.bus_byte    = data;
    r.chip_select = cs;
    return r;
  endfunction

  task automatic send_request(input in_item_t req);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // mostly data accesses; commands often park the cursor near a half end
  function automatic in_item_t random_request();
    int         pick;
    logic [1:0] cs;
    logic [7:0] data;
    pick = $urandom_range(0, 99);
    cs   = ($urandom_range(0, 15) == 0) ? HALF_NONE : 2'($urandom_range(1, 3));
    data = 8'($urandom_range(0, 255));
    if (pick < 3) return make_request(OP_NONE, data, 2'($urandom_range(0, 3)));
    if (pick < 15) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: data = SET_COL_CODE | 8'($urandom_range(56, 63));
        4, 5:       data = SET_PAGE_CODE | 8'($urandom_range(0, 7));
        default:    ;
      endcase
      return make_request(OP_CMD, data, cs);
    end
    if (pick < 70) return make_request(OP_WRITE, data, 2'($urandom_range(0, 3)));
    return make_request(OP_READ, data, 2'($urandom_range(0, 3)));
  endfunction

  task automatic send_random(input int count, input bit allow_idle);
    in_item_t req;
    int       sent;
    sent = 0;
    while (sent < count) begin
      if (allow_idle && sent % 25 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end
      req = random_request();
      send_request(req);
      if (req.op != OP_NONE) sent++;
    end
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    in_item_t directed[$];
    tx_idle_on = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni     <= 1'b1;
    rx_idle_on <= 1'b1;
    @(posedge clk_i);

    directed = '{
      make_request(OP_CMD,   8'h00, CS_BOTH),
      make_request(OP_CMD,   8'hFF, HALF_LEFT),
      make_request(OP_WRITE, 8'h00, HALF_LEFT),
      make_request(OP_READ,  8'h00, HALF_RIGHT),
      make_request(OP_WRITE, 8'hFF, CS_BOTH),
      make_request(OP_NONE,  8'hA5, HALF_NONE),
      // left half end, then wrap into the right half
      make_request(OP_CMD,   SET_COL_CODE | COL_MASK, HALF_LEFT),
      make_request(OP_WRITE, 8'h5A, HALF_LEFT),
      make_request(OP_WRITE, 8'hC3, HALF_LEFT),
      // right half end, then page advance on the write after the read
      make_request(OP_CMD,   SET_COL_CODE | COL_MASK, HALF_RIGHT),
      make_request(OP_READ,  8'hFF, HALF_NONE),
      make_request(OP_WRITE, 8'h3C, CS_BOTH),
      // last write of the panel
      make_request(OP_CMD,   SET_PAGE_CODE | PAGE_MASK, CS_BOTH),
      make_request(OP_CMD,   SET_COL_CODE | COL_MASK, HALF_RIGHT),
      make_request(OP_WRITE, 8'h81, HALF_LEFT),
      // read at the panel end, page wraps on the following access
      make_request(OP_CMD,   SET_PAGE_CODE | PAGE_MASK, HALF_RIGHT),
      make_request(OP_CMD,   SET_COL_CODE | COL_MASK, CS_BOTH),
      make_request(OP_READ,  8'h00, HALF_LEFT),
      make_request(OP_READ,  8'h00, HALF_LEFT),
      // no chip selected
      make_request(OP_CMD,   SET_COL_CODE | COL_MASK, HALF_NONE),
      make_request(OP_WRITE, 8'h11, HALF_NONE),
      make_request(OP_WRITE, 8'h22, HALF_NONE),
      make_request(OP_READ,  8'h00, HALF_NONE),
      make_request(OP_CMD,   SET_COL_CODE, CS_BOTH),
      make_request(OP_CMD,   SET_PAGE_CODE, HALF_LEFT)
    };
    foreach (directed[i]) send_request(directed[i]);

    send_random(150, 1'b1);

    // receiver holds off while requests keep coming
    tx_idle_on = 1'b0;
    -> start_hold;
    send_random(40, 1'b0);

    // sender pauses until the block is empty
    in_valid <= 1'b0;
    wait_drained();
    @(posedge clk_i);

    send_random(120, 1'b1);

    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    send_random(80, 1'b0);

    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    sb.report_leftovers();

    $display("covered %0d requests (%0d reads), %0d bus cycles checked",
             sb.requests_seen, sb.reads_seen, sb.cycles_checked);
    $display("cursor wraps: %0d page advances, %0d panel ends, %0d failures",
             sb.page_advances, sb.panel_ends, sb.failures);
    if (sb.failures == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
